// File: hdl/ccx_pkg.sv
// Package: shared types and constants for the ChaCha keystream XOR block.
package ccx_pkg;

    typedef struct packed {
        logic [63:0] data_chunk;
        logic [3:0]  byte_count;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_chunk;
        logic [3:0]  result_byte_count;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_KEY_4_5    = 3'd0,
        REG_KEY_6_7    = 3'd1,
        REG_KEY_8_9    = 3'd2,
        REG_KEY_10_11  = 3'd3,
        REG_NONCE_13_14 = 3'd4,
        REG_NONCE_15   = 3'd5,
        REG_ROUNDS     = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COLUMN,
        ST_DIAG,
        ST_FINAL,
        ST_XOR,
        ST_OUT
    } ccx_state_t;

    typedef struct packed {
        logic load_state;
        logic column_round;
        logic diag_round;
        logic add_back;
        logic do_xor;
        logic advance;
    } ccx_cmd_t;

    typedef struct packed {
        logic need_block;
        logic last_round;
    } ccx_status_t;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;
    localparam logic [3:0]  ROUND_RESET = 4'd10;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [127:0] quarter(input logic [127:0] abcd);
        logic [31:0] a, b, c, d;
        a = abcd[127:96];
        b = abcd[95:64];
        c = abcd[63:32];
        d = abcd[31:0];
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        quarter = {a, b, c, d};
    endfunction

endpackage

// File: hdl/ccx_ctrl.sv
// Controller: sequences block generation and chunk transactions.
module ccx_ctrl
    import ccx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  ccx_status_t status,
    output ccx_cmd_t    cmd
);

    ccx_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.need_block)
                    begin
                        cmd.load_state = 1'b1;
                        state_next = ST_COLUMN;
                    end
                    else
                    begin
                        state_next = ST_XOR;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_COLUMN;
            end
            ST_COLUMN:
            begin
                if (status.last_round)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    cmd.column_round = 1'b1;
                    state_next = ST_DIAG;
                end
            end
            ST_DIAG:
            begin
                cmd.diag_round = 1'b1;
                state_next = ST_COLUMN;
            end
            ST_FINAL:
            begin
                cmd.add_back = 1'b1;
                state_next = ST_XOR;
            end
            ST_XOR:
            begin
                cmd.do_xor = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/ccx_datapath.sv
// Datapath: config registers, round state, four quarter-round units, XOR.
module ccx_datapath
    import ccx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_take,
    input  in_item_t    in_item,
    input  ccx_cmd_t    cmd,
    output ccx_status_t status,
    output out_item_t   out_item
);

    logic [31:0] base_reg [4:15];
    logic [3:0]  rounds_reg;
    logic [31:0] counter_reg;
    logic [2:0]  pos_reg;
    logic [3:0]  round_cnt_reg;
    logic [31:0] w_reg [16];
    logic [31:0] in_word [16];
    in_item_t    item_reg;
    out_item_t   out_reg;

    logic [127:0] q_in  [4];
    logic [127:0] q_out [4];
    logic [3:0]   cnt_sat;
    logic [63:0]  mask;
    logic [63:0]  ks;

    assign in_word[0]  = SIGMA0;
    assign in_word[1]  = SIGMA1;
    assign in_word[2]  = SIGMA2;
    assign in_word[3]  = SIGMA3;
    assign in_word[12] = counter_reg;
    generate
        for (genvar g = 4; g < 16; g++)
        begin : g_in
            if (g != 12)
            begin : g_b
                assign in_word[g] = base_reg[g];
            end
        end
    endgenerate

    assign status.need_block = (pos_reg == 3'd0);
    assign status.last_round = (round_cnt_reg == 4'd0);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (cmd.diag_round)
            begin
                q_in[i] = {w_reg[i], w_reg[4 + ((i + 1) % 4)],
                           w_reg[8 + ((i + 2) % 4)], w_reg[12 + ((i + 3) % 4)]};
            end
            else
            begin
                q_in[i] = {w_reg[i], w_reg[4 + i], w_reg[8 + i], w_reg[12 + i]};
            end
            q_out[i] = quarter(q_in[i]);
        end
    end

    always_comb
    begin
        cnt_sat = (item_reg.byte_count > 4'd8) ? 4'd8 : item_reg.byte_count;
        for (int b = 0; b < 8; b++)
        begin
            mask[8*b +: 8] = (4'(b) < cnt_sat) ? 8'hff : 8'h00;
        end
        ks = {w_reg[{pos_reg, 1'b1}], w_reg[{pos_reg, 1'b0}]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 4; i < 16; i++)
            begin
                base_reg[i] <= '0;
            end
            rounds_reg    <= ROUND_RESET;
            counter_reg   <= '0;
            pos_reg       <= '0;
            round_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index <= REG_ROUNDS)
            begin
                counter_reg <= '0;
                pos_reg     <= '0;
                case (cfg_index)
                    REG_KEY_4_5:     begin base_reg[4]  <= cfg_data[63:32];
                                           base_reg[5]  <= cfg_data[31:0]; end
                    REG_KEY_6_7:     begin base_reg[6]  <= cfg_data[63:32];
                                           base_reg[7]  <= cfg_data[31:0]; end
                    REG_KEY_8_9:     begin base_reg[8]  <= cfg_data[63:32];
                                           base_reg[9]  <= cfg_data[31:0]; end
                    REG_KEY_10_11:   begin base_reg[10] <= cfg_data[63:32];
                                           base_reg[11] <= cfg_data[31:0]; end
                    REG_NONCE_13_14: begin base_reg[13] <= cfg_data[63:32];
                                           base_reg[14] <= cfg_data[31:0]; end
                    REG_NONCE_15:    base_reg[15] <= cfg_data[31:0];
                    REG_ROUNDS:      rounds_reg <= cfg_data[3:0];
                    default:         ;
                endcase
            end
            if (cmd.load_state)
            begin
                round_cnt_reg <= rounds_reg;
            end
            else if (cmd.column_round)
            begin
                round_cnt_reg <= round_cnt_reg - 4'd1;
            end
            if (cmd.add_back)
            begin
                counter_reg <= counter_reg + 32'd1;
            end
            if (cmd.advance)
            begin
                pos_reg <= pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_item;
        end
        if (cmd.load_state)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= in_word[i];
            end
        end
        else if (cmd.column_round)
        begin
            for (int i = 0; i < 4; i++)
            begin
                {w_reg[i], w_reg[4 + i], w_reg[8 + i], w_reg[12 + i]} <= q_out[i];
            end
        end
        else if (cmd.diag_round)
        begin
            for (int i = 0; i < 4; i++)
            begin
                {w_reg[i], w_reg[4 + ((i + 1) % 4)], w_reg[8 + ((i + 2) % 4)],
                 w_reg[12 + ((i + 3) % 4)]} <= q_out[i];
            end
        end
        else if (cmd.add_back)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= w_reg[i] + in_word[i];
            end
        end
        if (cmd.do_xor)
        begin
            out_reg.result_chunk      <= (item_reg.data_chunk ^ ks) & mask;
            out_reg.result_byte_count <= cnt_sat;
        end
    end

    assign out_item = out_reg;

endmodule

// File: hdl/chacha20_keystream_xor.sv
// Top level: ChaCha keystream XOR over 8-byte chunks.
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes key, nonce
//   and double-round count; any valid write to index 0 to 6 clears the block
//   counter and the chunk position. Write only while the block is idle.
//   in channel (in_valid/in_ready, in_data) takes one chunk per transaction;
//   out channel (out_valid/out_ready, out_data) returns one chunk per input.
// Sequencing:
//   A chunk at block position 0 runs the block function: the accepting edge
//   loads the state, then each double round is a column step and then a
//   diagonal step on four parallel quarter-round units; a step to see the
//   round count run out, an add-back step and an XOR step come before the
//   result transaction, and the next chunk can be taken in the cycle after
//   it. Other chunks go from acceptance through the XOR step to the result.
//   One chunk in flight.
// Reset:
//   Key and nonce clear to zero, double-round count to 10, counter to 0.
// Stall:
//   The result holds on out_data until out_ready; no new chunk is taken.
module chacha20_keystream_xor
    import ccx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    ccx_cmd_t    cmd;
    ccx_status_t status;

    assign cfg_ready = 1'b1;

    ccx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ccx_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_take   (in_valid && in_ready),
        .in_item   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_data)
    );

endmodule

// File: hdl/ccx_checker.sv
// Checker: port-level properties of the keystream XOR block.
module ccx_checker
    import ccx_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.result_byte_count <= 4'd8)
        else $error("result byte count above eight");

    a_take_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result without processing");

endmodule

bind chacha20_keystream_xor ccx_checker u_ccx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/chacha20_keystream_xor_tb.sv
// Testbench for chacha20_keystream_xor: directed and random chunks checked against a ChaCha model.
module chacha20_keystream_xor_tb;
    import ccx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;

    logic [31:0] key_nonce_words [16];
    logic [31:0] ks_words [16];
    logic [31:0] blk_ctr;
    logic [2:0]  chunk_pos;
    logic [3:0]  dbl_rounds;
    out_item_t   expected_chunks [$];
    int          errors = 0;
    bit          drain_stalls = 1'b0;

    chacha20_keystream_xor u_dut (.*);

    always #4 clk = ~clk;

    function automatic logic [31:0] rol32(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic qround(inout logic [31:0] w [16], input int a, b, c, d);
        w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 16);
        w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 12);
        w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 8);
        w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 7);
    endtask

    task automatic compute_block();
        logic [31:0] init [16];
        init = key_nonce_words;
        init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
        init[12] = blk_ctr;
        ks_words = init;
        for (int r = 0; r < dbl_rounds; r++)
        begin
            qround(ks_words, 0, 4, 8, 12); qround(ks_words, 1, 5, 9, 13);
            qround(ks_words, 2, 6, 10, 14); qround(ks_words, 3, 7, 11, 15);
            qround(ks_words, 0, 5, 10, 15); qround(ks_words, 1, 6, 11, 12);
            qround(ks_words, 2, 7, 8, 13); qround(ks_words, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            ks_words[i] += init[i];
        blk_ctr++;
    endtask

    task automatic predict_chunk(in_item_t it);
        out_item_t   e;
        logic [3:0]  n;
        logic [63:0] ks, mask;
        n = (it.byte_count > 8) ? 4'd8 : it.byte_count;
        if (chunk_pos == 0)
            compute_block();
        ks = {ks_words[2 * chunk_pos + 1], ks_words[2 * chunk_pos]};
        mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 1);
        e.result_chunk = (it.data_chunk ^ ks) & mask;
        e.result_byte_count = n;
        expected_chunks.push_back(e);
        chunk_pos++;
    endtask

    task automatic wait_gap(int lim);
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, lim) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_chunk(logic [63:0] d, logic [3:0] n, bit gaps = 1);
        if (gaps)
            wait_gap(30);
        in_valid <= 1'b1;
        in_data <= '{data_chunk: d, byte_count: n};
        do @(posedge clk); while (!in_ready);
        predict_chunk('{data_chunk: d, byte_count: n});
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_chunks.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= 3)
        begin
            key_nonce_words[4 + 2 * idx] = v[63:32];
            key_nonce_words[5 + 2 * idx] = v[31:0];
        end
        else if (idx == REG_NONCE_13_14)
        begin
            key_nonce_words[13] = v[63:32];
            key_nonce_words[14] = v[31:0];
        end
        else if (idx == REG_NONCE_15)
            key_nonce_words[15] = v[31:0];
        else if (idx == REG_ROUNDS)
            dbl_rounds = v[3:0];
        if (idx <= REG_ROUNDS)
        begin
            blk_ctr = '0;
            chunk_pos = '0;
        end
        @(posedge clk);
    endtask

    task automatic load_config(logic [63:0] fill, logic [3:0] rounds);
        write_reg(REG_KEY_4_5, fill);
        write_reg(REG_KEY_6_7, ~fill);
        write_reg(REG_KEY_8_9, {fill[31:0], fill[63:32]});
        write_reg(REG_KEY_10_11, fill ^ 64'h0123_4567_89ab_cdef);
        write_reg(REG_NONCE_13_14, ~{fill[31:0], fill[63:32]});
        write_reg(REG_NONCE_15, fill);
        write_reg(REG_ROUNDS, {60'd0, rounds});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_reset_defaults();
        for (int i = 0; i < 16; i++)
            send_chunk(i[0] ? '1 : '0, 4'd8);
    endtask

    task automatic test_byte_counts();
        load_config(64'hffff_ffff_ffff_ffff, 4'd15);
        for (int n = 0; n < 16; n++)
            send_chunk(rand64(), n[3:0]);
        wait_drain();
        write_reg(3'd7, rand64());
        send_chunk(rand64(), 4'd8);
        wait_drain();
    endtask

    task automatic test_round_extremes();
        load_config(64'd0, 4'd0);
        repeat (9) send_chunk(rand64(), 4'd8);
        wait_drain();
        load_config(rand64(), 4'd1);
        repeat (9) send_chunk(rand64(), 4'($urandom_range(0, 15)));
        wait_drain();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drain();
            load_config(rand64(), (phase == 0) ? 4'd10 : 4'($urandom_range(1, 15)));
            for (int i = 0; i < 200; i++)
                send_chunk(rand64(),
                    ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'd8);
            wait_drain();
        end
    endtask

    task automatic test_back_to_back();
        drain_stalls = 1'b1;
        repeat (40) send_chunk(rand64(), 4'($urandom_range(1, 8)), 0);
        wait_drain();
        drain_stalls = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
        begin
            key_nonce_words[i] = '0;
            ks_words[i] = '0;
        end
        blk_ctr = '0;
        chunk_pos = '0;
        dbl_rounds = ROUND_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        wait_drain();
        test_byte_counts();
        test_round_extremes();
        test_random_traffic();
        test_back_to_back();
        wait_drain();
        if (errors == 0)
            $display("[chacha20_keystream_xor] OK");
        else
            $display("[chacha20_keystream_xor] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (drain_stalls || $urandom_range(0, 3) != 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'($urandom_range(0, 1));
    end

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chunks.size() == 0)
            begin
                $display("%0t unexpected transaction: expected none actual %h",
                    $time, out_data);
                errors++;
            end
            else
            begin
                e = expected_chunks.pop_front();
                if (out_data.result_chunk !== e.result_chunk)
                begin
                    $display("%0t result_chunk: expected %h actual %h",
                        $time, e.result_chunk, out_data.result_chunk);
                    errors++;
                end
                if (out_data.result_byte_count !== e.result_byte_count)
                begin
                    $display("%0t result_byte_count: expected %0d actual %0d",
                        $time, e.result_byte_count, out_data.result_byte_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("[chacha20_keystream_xor] ERROR");
        $finish;
    end
endmodule

// File: filelist.f
hdl/ccx_pkg.sv
hdl/ccx_ctrl.sv
hdl/ccx_datapath.sv
hdl/chacha20_keystream_xor.sv
hdl/ccx_checker.sv
tb/chacha20_keystream_xor_tb.sv
